// ----- hdl/cbam_pkg.sv -----
// cbam_pkg: shared types and constants for the cartridge bank address mapper
// used by every module of the block and by its checker; no dependencies
`default_nettype none

package cbam_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 22;
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int MAP_W       = 22;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_ROM_MASK       = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_ROM_MASK       = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKUP_RAM_MASK    = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKUP_RAM_PRESENT = 4'd3;

    localparam logic [1:0] CMD_CPU_READ  = 2'd0;
    localparam logic [1:0] CMD_CPU_WRITE = 2'd1;
    localparam logic [1:0] CMD_PPU_READ  = 2'd2;
    localparam logic [1:0] CMD_PPU_WRITE = 2'd3;

    // cpu address bits 15:13
    localparam logic [2:0] REGION_SYSRAM = 3'd0;
    localparam logic [2:0] REGION_PPUREG = 3'd1;
    localparam logic [2:0] REGION_APUREG = 3'd2;
    localparam logic [2:0] REGION_BACKUP = 3'd3;

    // cpu address bits 14:12 of a register write
    localparam logic [2:0] BANK_SEL_NT0  = 3'd4;
    localparam logic [2:0] BANK_SEL_NT1  = 3'd5;
    localparam logic [2:0] BANK_SEL_CTRL = 3'd6;
    localparam logic [2:0] BANK_SEL_PRG  = 3'd7;

    typedef enum logic [3:0] {
        TGT_SYSRAM = 4'd0,
        TGT_PPUREG = 4'd1,
        TGT_APUREG = 4'd2,
        TGT_BACKUP = 4'd3,
        TGT_PRG    = 4'd4,
        TGT_CHRROM = 4'd5,
        TGT_NTRAM  = 4'd6,
        TGT_NONE   = 4'd7,
        TGT_CHRRAM = 4'd8
    } target_t;

    typedef struct packed {
        logic [21:0] prg_rom_mask;
        logic [18:0] chr_rom_mask;
        logic [12:0] backup_ram_mask;
        logic        backup_ram_present;
    } cfg_t;

    typedef struct packed {
        logic [3:0][7:0] pattern_bank;
        logic [1:0][6:0] nametable_rom_bank;
        logic            nametable_rom_mode;
        logic            mirroring_select;
        logic [7:0]      program_bank;
    } bank_state_t;

    typedef struct packed {
        logic       en;
        logic [2:0] sel;
        logic [7:0] data;
    } bank_wr_t;

endpackage

`default_nettype wire

// ----- hdl/cbam_regs.sv -----
// cbam_regs: configuration registers and mapper bank registers
// depends on cbam_pkg
`default_nettype none

module cbam_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_write,
    input  wire logic [cbam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cbam_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire cbam_pkg::bank_wr_t               bank_wr,
    output cbam_pkg::cfg_t                        cfg,
    output cbam_pkg::bank_state_t                 banks
);

    cbam_pkg::cfg_t        cfg_reg;
    cbam_pkg::cfg_t        cfg_next;
    cbam_pkg::bank_state_t banks_reg;
    cbam_pkg::bank_state_t banks_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                cbam_pkg::CFG_PRG_ROM_MASK:
                    cfg_next.prg_rom_mask = cfg_data[21:0];
                cbam_pkg::CFG_CHR_ROM_MASK:
                    cfg_next.chr_rom_mask = cfg_data[18:0];
                cbam_pkg::CFG_BACKUP_RAM_MASK:
                    cfg_next.backup_ram_mask = cfg_data[12:0];
                cbam_pkg::CFG_BACKUP_RAM_PRESENT:
                    cfg_next.backup_ram_present = cfg_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        banks_next = banks_reg;
        if (bank_wr.en)
        begin
            case (bank_wr.sel)
                cbam_pkg::BANK_SEL_NT0:
                    banks_next.nametable_rom_bank[0] = bank_wr.data[6:0];
                cbam_pkg::BANK_SEL_NT1:
                    banks_next.nametable_rom_bank[1] = bank_wr.data[6:0];
                cbam_pkg::BANK_SEL_CTRL:
                begin
                    banks_next.nametable_rom_mode = bank_wr.data[4];
                    banks_next.mirroring_select   = bank_wr.data[0];
                end
                cbam_pkg::BANK_SEL_PRG:
                    banks_next.program_bank = bank_wr.data;
                default:
                    banks_next.pattern_bank[bank_wr.sel[1:0]] = bank_wr.data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_rom_mask       <= 22'h03FFFF;
            cfg_reg.chr_rom_mask       <= 19'h3FFFF;
            cfg_reg.backup_ram_mask    <= 13'h1FFF;
            cfg_reg.backup_ram_present <= 1'b1;
            banks_reg                  <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            banks_reg <= banks_next;
        end
    end

    assign cfg   = cfg_reg;
    assign banks = banks_reg;

endmodule

`default_nettype wire

// ----- hdl/cbam_decode.sv -----
// cbam_decode: access decode and address translation for one cpu or ppu access
// depends on cbam_pkg; combinational only
`default_nettype none

module cbam_decode (
    input  wire logic [1:0]                  cmd,
    input  wire logic [cbam_pkg::ADDR_W-1:0] address,
    input  wire logic [cbam_pkg::DATA_W-1:0] data,
    input  wire cbam_pkg::cfg_t              cfg,
    input  wire cbam_pkg::bank_state_t       banks,
    output cbam_pkg::target_t                target,
    output logic [cbam_pkg::MAP_W-1:0]       mapped_address,
    output cbam_pkg::bank_wr_t               bank_wr
);

    logic       is_write;
    logic [7:0] prg_bank;
    logic [7:0] chr_bank;
    logic [7:0] nt_bank;
    logic       nt_sel;

    always_comb
    begin
        is_write = (cmd == cbam_pkg::CMD_CPU_WRITE) || (cmd == cbam_pkg::CMD_PPU_WRITE);
        // upper 16kb fixed to the last bank
        prg_bank = (address[14] ? 8'hFF : banks.program_bank) & cfg.prg_rom_mask[21:14];
        chr_bank = banks.pattern_bank[address[12:11]] & cfg.chr_rom_mask[18:11];
        nt_sel   = banks.mirroring_select ? address[11] : address[10];
        nt_bank  = {1'b1, banks.nametable_rom_bank[nt_sel]} & cfg.chr_rom_mask[17:10];

        target         = cbam_pkg::TGT_NONE;
        mapped_address = '0;
        bank_wr.en     = 1'b0;
        bank_wr.sel    = address[14:12];
        bank_wr.data   = data;

        if (!cmd[1])
        begin
            case (address[15:13])
                cbam_pkg::REGION_SYSRAM:
                begin
                    target         = cbam_pkg::TGT_SYSRAM;
                    mapped_address = {11'd0, address[10:0]};
                end
                cbam_pkg::REGION_PPUREG:
                begin
                    target         = cbam_pkg::TGT_PPUREG;
                    mapped_address = {6'd0, address};
                end
                cbam_pkg::REGION_APUREG:
                begin
                    target         = cbam_pkg::TGT_APUREG;
                    mapped_address = {6'd0, address};
                end
                cbam_pkg::REGION_BACKUP:
                begin
                    if (cfg.backup_ram_present)
                    begin
                        target         = cbam_pkg::TGT_BACKUP;
                        mapped_address = {9'd0, address[12:0] & cfg.backup_ram_mask};
                    end
                end
                default:
                begin
                    if (is_write)
                        bank_wr.en = 1'b1;
                    else
                    begin
                        target         = cbam_pkg::TGT_PRG;
                        mapped_address = {prg_bank, address[13:0]};
                    end
                end
            endcase
        end
        else if (!address[13])
        begin
            if (is_write)
            begin
                target         = cbam_pkg::TGT_CHRRAM;
                mapped_address = {9'd0, address[12:0]};
            end
            else
            begin
                target         = cbam_pkg::TGT_CHRROM;
                mapped_address = {3'd0, chr_bank, address[10:0]};
            end
        end
        else if (banks.nametable_rom_mode)
        begin
            // writes to rom nametables are dropped
            if (!is_write)
            begin
                target         = cbam_pkg::TGT_CHRROM;
                mapped_address = {4'd0, nt_bank, address[9:0]};
            end
        end
        else if (banks.mirroring_select)
        begin
            target         = cbam_pkg::TGT_NTRAM;
            mapped_address = {11'd0, address[11], address[9:0]};
        end
        else
        begin
            target         = cbam_pkg::TGT_NTRAM;
            mapped_address = {11'd0, address[10:0]};
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cartridge_bank_address_mapper.sv -----
// cartridge_bank_address_mapper: top level of the bank address mapper
// depends on cbam_pkg, cbam_regs and cbam_decode
//
// Usage
//   Input channel (in_valid/in_ready, cmd/address/data) carries one cpu or ppu
//   access per transfer; the output channel (out_valid/out_ready,
//   target/mapped_address) returns exactly one result per access, in order.
//   cpu writes at 0x8000-0xffff update the bank registers and return target none.
//   Configuration is a plain write port (cfg_write/cfg_index/cfg_data), index 0
//   prg rom mask, 1 chr rom mask, 2 backup ram mask, 3 backup ram present;
//   other indexes are ignored. Write it only while the block is idle.
// Pipeline and throughput
//   An accepted access sits in the input register, is decoded and lands in the
//   result register once that register is free. One access per cycle sustained
//   while out_ready is high; the bank registers update as a cpu write leaves the
//   input register, so the following access already sees them.
// Reset and stall
//   Reset empties both pipeline registers and loads the bank and configuration
//   registers with their defaults. When out_ready is low the result holds and
//   the input register fills; in_ready drops only when both are occupied.
`default_nettype none

module cartridge_bank_address_mapper (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       cmd,
    input  wire logic [cbam_pkg::ADDR_W-1:0]      address,
    input  wire logic [cbam_pkg::DATA_W-1:0]      data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [3:0]                            target,
    output logic [cbam_pkg::MAP_W-1:0]            mapped_address,
    input  wire logic                             cfg_write,
    input  wire logic [cbam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cbam_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [1:0]                  s1_cmd_reg;
    logic [cbam_pkg::ADDR_W-1:0] s1_address_reg;
    logic [cbam_pkg::DATA_W-1:0] s1_data_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [3:0]                  target_reg;
    logic [cbam_pkg::MAP_W-1:0]  mapped_address_reg;

    logic                        in_xfer;
    logic                        res_free;
    logic                        s1_adv;

    cbam_pkg::cfg_t              cfg;
    cbam_pkg::bank_state_t       banks;
    cbam_pkg::bank_wr_t          dec_bank_wr;
    cbam_pkg::bank_wr_t          bank_wr;
    cbam_pkg::target_t           dec_target;
    logic [cbam_pkg::MAP_W-1:0]  dec_mapped_address;

    assign res_free = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && res_free;
    assign in_ready = !s1_valid_reg || res_free;
    assign in_xfer  = in_valid && in_ready;

    cbam_decode u_decode (
        .cmd            (s1_cmd_reg),
        .address        (s1_address_reg),
        .data           (s1_data_reg),
        .cfg            (cfg),
        .banks          (banks),
        .target         (dec_target),
        .mapped_address (dec_mapped_address),
        .bank_wr        (dec_bank_wr)
    );

    always_comb
    begin
        bank_wr    = dec_bank_wr;
        bank_wr.en = dec_bank_wr.en && s1_adv;
    end

    cbam_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bank_wr   (bank_wr),
        .cfg       (cfg),
        .banks     (banks)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cmd_reg     <= cmd;
            s1_address_reg <= address;
            s1_data_reg    <= data;
        end
        if (s1_adv)
        begin
            target_reg         <= dec_target;
            mapped_address_reg <= dec_mapped_address;
        end
    end

    assign out_valid      = out_valid_reg;
    assign target         = target_reg;
    assign mapped_address = mapped_address_reg;

endmodule

`default_nettype wire

// ----- hdl/cbam_checker.sv -----
// cbam_checker: port-level assertions for the bank address mapper
// depends on cbam_pkg; bound to cartridge_bank_address_mapper below
`default_nettype none

module cbam_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [3:0]                  target,
    input wire logic [cbam_pkg::MAP_W-1:0]  mapped_address
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target) && $stable(mapped_address))
        else $error("result changed while stalled");

    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> target <= cbam_pkg::TGT_CHRRAM)
        else $error("target code out of range");

    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == cbam_pkg::TGT_NONE |-> mapped_address == '0)
        else $error("target none with nonzero address");

    a_sysram_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == cbam_pkg::TGT_SYSRAM |-> mapped_address[21:11] == '0)
        else $error("system ram address beyond 2kb");

    a_chrram_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == cbam_pkg::TGT_CHRRAM || target == cbam_pkg::TGT_NTRAM)
        |-> mapped_address[21:13] == '0)
        else $error("chr or nametable ram address beyond 8kb");

endmodule

bind cartridge_bank_address_mapper cbam_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .target         (target),
    .mapped_address (mapped_address)
);

`default_nettype wire

// ----- bench/cbam_scoreboard_pkg.sv -----
// cbam_scoreboard_pkg: bank and mirroring predictor with an in-order result scoreboard
// for the cartridge bank address mapper; depends on cbam_pkg for types and codes
package cbam_scoreboard_pkg;

    typedef struct packed {
        cbam_pkg::target_t tgt;
        logic [21:0]       addr;
    } mapped_access_t;

    class bank_map_scoreboard;

        cbam_pkg::cfg_t        settings;
        cbam_pkg::bank_state_t banks;
        mapped_access_t        pending_maps[$];
        int unsigned           accesses_noted;
        int unsigned           matched_count;
        int unsigned           error_count;
        int unsigned           bank_writes;
        int unsigned           target_hits[9];

        function new();
            settings.prg_rom_mask       = 22'h03FFFF;
            settings.chr_rom_mask       = 19'h3FFFF;
            settings.backup_ram_mask    = 13'h1FFF;
            settings.backup_ram_present = 1'b1;
            banks          = '0;
            accesses_noted = 0;
            matched_count  = 0;
            error_count    = 0;
            bank_writes    = 0;
            foreach (target_hits[i])
            begin
                target_hits[i] = 0;
            end
        endfunction

        function void write_register(logic [cbam_pkg::CFG_INDEX_W-1:0] index,
                                     logic [cbam_pkg::CFG_DATA_W-1:0] value);
            case (index)
                cbam_pkg::CFG_PRG_ROM_MASK:
                    settings.prg_rom_mask       = value[21:0];
                cbam_pkg::CFG_CHR_ROM_MASK:
                    settings.chr_rom_mask       = value[18:0];
                cbam_pkg::CFG_BACKUP_RAM_MASK:
                    settings.backup_ram_mask    = value[12:0];
                cbam_pkg::CFG_BACKUP_RAM_PRESENT:
                    settings.backup_ram_present = value[0];
                default: ;
            endcase
        endfunction

        // decode one access, update the bank registers on a register write
        function mapped_access_t translate(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata);
            mapped_access_t r;
            logic [13:0]    pa;
            logic           sel;
            logic [18:0]    chr_base;
            r.tgt  = cbam_pkg::TGT_NONE;
            r.addr = '0;
            pa     = addr[13:0];
            if (op == cbam_pkg::CMD_CPU_READ || op == cbam_pkg::CMD_CPU_WRITE)
            begin
                if (!addr[15])
                begin
                    case (addr[15:13])
                        cbam_pkg::REGION_SYSRAM:
                        begin
                            r.tgt  = cbam_pkg::TGT_SYSRAM;
                            r.addr = 22'(addr[10:0]);
                        end
                        cbam_pkg::REGION_PPUREG:
                        begin
                            r.tgt  = cbam_pkg::TGT_PPUREG;
                            r.addr = 22'(addr);
                        end
                        cbam_pkg::REGION_APUREG:
                        begin
                            r.tgt  = cbam_pkg::TGT_APUREG;
                            r.addr = 22'(addr);
                        end
                        cbam_pkg::REGION_BACKUP:
                        begin
                            if (settings.backup_ram_present)
                            begin
                                r.tgt  = cbam_pkg::TGT_BACKUP;
                                r.addr = 22'(addr[12:0] & settings.backup_ram_mask);
                            end
                        end
                        default: ;
                    endcase
                end
                else if (op == cbam_pkg::CMD_CPU_READ)
                begin
                    r.tgt = cbam_pkg::TGT_PRG;
                    if (!addr[14])
                        r.addr = ({banks.program_bank, 14'h0} & settings.prg_rom_mask & ~22'h3FFF)
                                 | 22'(addr[13:0]);
                    else
                        r.addr = (settings.prg_rom_mask & ~22'h3FFF) | 22'(addr[13:0]);
                end
                else
                begin
                    bank_writes++;
                    case (addr[14:12])
                        cbam_pkg::BANK_SEL_NT0:  banks.nametable_rom_bank[0] = wdata[6:0];
                        cbam_pkg::BANK_SEL_NT1:  banks.nametable_rom_bank[1] = wdata[6:0];
                        cbam_pkg::BANK_SEL_CTRL:
                        begin
                            banks.nametable_rom_mode = wdata[4];
                            banks.mirroring_select   = wdata[0];
                        end
                        cbam_pkg::BANK_SEL_PRG:  banks.program_bank = wdata;
                        default:                 banks.pattern_bank[addr[13:12]] = wdata;
                    endcase
                end
            end
            else if (!pa[13])
            begin
                if (op == cbam_pkg::CMD_PPU_WRITE)
                begin
                    r.tgt  = cbam_pkg::TGT_CHRRAM;
                    r.addr = 22'(pa[12:0]);
                end
                else
                begin
                    chr_base = {banks.pattern_bank[pa[12:11]], 11'h0} & settings.chr_rom_mask
                               & ~19'h7FF;
                    r.tgt    = cbam_pkg::TGT_CHRROM;
                    r.addr   = 22'(chr_base | 19'(pa[10:0]));
                end
            end
            else if (banks.nametable_rom_mode)
            begin
                // nametable rom: writes are dropped
                if (op == cbam_pkg::CMD_PPU_READ)
                begin
                    sel      = banks.mirroring_select ? pa[11] : pa[10];
                    chr_base = 19'({1'b1, banks.nametable_rom_bank[sel], 10'h0})
                               & settings.chr_rom_mask & ~19'h3FF;
                    r.tgt    = cbam_pkg::TGT_CHRROM;
                    r.addr   = 22'(chr_base | 19'(pa[9:0]));
                end
            end
            else if (banks.mirroring_select)
            begin
                r.tgt  = cbam_pkg::TGT_NTRAM;
                r.addr = 22'({pa[11], pa[9:0]});
            end
            else
            begin
                r.tgt  = cbam_pkg::TGT_NTRAM;
                r.addr = 22'(pa[10:0]);
            end
            return r;
        endfunction

        function void note_access(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata);
            mapped_access_t r;
            r = translate(op, addr, wdata);
            pending_maps.push_back(r);
            accesses_noted++;
            target_hits[r.tgt]++;
        endfunction

        function void check_result(logic [3:0] tgt, logic [21:0] addr);
            mapped_access_t want;
            if (pending_maps.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("result with no access pending: target %0d address %h", tgt, addr);
                return;
            end
            want = pending_maps.pop_front();
            if (tgt !== want.tgt || addr !== want.addr)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("mismatch: target expected %0d got %0d, address expected %h got %h",
                             want.tgt, tgt, want.addr, addr);
            end
            else
            begin
                matched_count++;
            end
        endfunction

        function void check_drained();
            if (pending_maps.size() != 0)
            begin
                error_count += pending_maps.size();
                $display("%0d results never arrived", pending_maps.size());
            end
        endfunction

    endclass

endpackage

// ----- bench/cartridge_bank_address_mapper_test.sv -----
// cartridge_bank_address_mapper_test: directed and random cpu/ppu accesses under
// random input gaps and output stalls; depends on cbam_pkg and cbam_scoreboard_pkg
module cartridge_bank_address_mapper_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PHASES          = 7;
    localparam int          ITEMS_PER_PHASE = 290;
    localparam int          DRAIN_CYCLES    = 6;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    logic [1:0]                       cmd       = '0;
    logic [cbam_pkg::ADDR_W-1:0]      address   = '0;
    logic [cbam_pkg::DATA_W-1:0]      data      = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic [3:0]                       target;
    logic [cbam_pkg::MAP_W-1:0]       mapped_address;
    logic                             cfg_write = 1'b0;
    logic [cbam_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cbam_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    logic        idling_on = 1'b1;
    int unsigned cycle_count = 0;
    int unsigned settings_used = 1;

    cbam_scoreboard_pkg::bank_map_scoreboard sb = new();

    cartridge_bank_address_mapper i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .address        (address),
        .data           (data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .target         (target),
        .mapped_address (mapped_address),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles", cycle_count);
            $display("cartridge_bank_address_mapper test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(target, mapped_address);
    end

    // receiver stalls in bursts
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idling_on && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    task automatic send_access(logic [1:0] op, logic [15:0] addr, logic [7:0] wdata);
        @(negedge clk);
        in_valid <= 1'b1;
        cmd      <= op;
        address  <= addr;
        data     <= wdata;
        do @(posedge clk); while (!in_ready);
        sb.note_access(op, addr, wdata);
    endtask

    task automatic idle_input(int unsigned cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_random_access();
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  wdata;
        int unsigned pick;
        pick  = $urandom_range(0, 7);
        op    = 2'($urandom_range(0, 3));
        addr  = 16'($urandom);
        wdata = 8'($urandom);
        if (pick < 2)
        begin
            op       = cbam_pkg::CMD_CPU_WRITE;
            addr[15] = 1'b1;
        end
        else if (pick < 4)
        begin
            op       = pick[0] ? cbam_pkg::CMD_PPU_WRITE : cbam_pkg::CMD_PPU_READ;
            addr[13] = 1'b1;
        end
        if (idling_on && $urandom_range(0, 5) == 0)
            idle_input($urandom_range(1, 12));
        send_access(op, addr, wdata);
    endtask

    task automatic wait_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_maps.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(logic [cbam_pkg::CFG_INDEX_W-1:0] index,
                                logic [cbam_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        sb.write_register(index, value);
    endtask

    task automatic configure(int phase);
        case (phase)
            1:
            begin
                write_config(cbam_pkg::CFG_PRG_ROM_MASK, '1);
                write_config(cbam_pkg::CFG_CHR_ROM_MASK, '1);
                write_config(cbam_pkg::CFG_BACKUP_RAM_MASK, '1);
                write_config(cbam_pkg::CFG_BACKUP_RAM_PRESENT, '1);
            end
            2:
            begin
                write_config(cbam_pkg::CFG_PRG_ROM_MASK, '0);
                write_config(cbam_pkg::CFG_CHR_ROM_MASK, '0);
                write_config(cbam_pkg::CFG_BACKUP_RAM_MASK, '0);
                write_config(cbam_pkg::CFG_BACKUP_RAM_PRESENT, '0);
            end
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    write_config(cbam_pkg::CFG_PRG_ROM_MASK,
                                 22'((32'd1 << $urandom_range(14, 22)) - 1));
                else
                    write_config(cbam_pkg::CFG_PRG_ROM_MASK, 22'($urandom));
                if ($urandom_range(0, 1) == 0)
                    write_config(cbam_pkg::CFG_CHR_ROM_MASK,
                                 22'((32'd1 << $urandom_range(11, 19)) - 1));
                else
                    write_config(cbam_pkg::CFG_CHR_ROM_MASK, 22'($urandom));
                write_config(cbam_pkg::CFG_BACKUP_RAM_MASK, 22'($urandom));
                write_config(cbam_pkg::CFG_BACKUP_RAM_PRESENT, 22'($urandom));
                // unused index must leave everything alone
                write_config(4'($urandom_range(int'(cbam_pkg::CFG_BACKUP_RAM_PRESENT) + 1, 15)),
                             22'($urandom));
            end
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    task automatic run_directed();
        send_access(cbam_pkg::CMD_CPU_READ,  16'h0000, 8'h00);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'h1FFF, 8'hFF);
        send_access(cbam_pkg::CMD_CPU_READ,  16'h2000, 8'h00);
        send_access(cbam_pkg::CMD_CPU_READ,  16'h5FFF, 8'h00);
        send_access(cbam_pkg::CMD_CPU_READ,  16'h6000, 8'h00);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'h7FFF, 8'hAA);
        send_access(cbam_pkg::CMD_CPU_READ,  16'h8000, 8'h00);
        send_access(cbam_pkg::CMD_CPU_READ,  16'hFFFF, 8'h00);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'h8000, 8'hFF);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'h9FFF, 8'h80);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'hA123, 8'h01);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'hBFFF, 8'h7F);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'hC000, 8'hFF);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'hDFFF, 8'h80);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'hF000, 8'hFF);
        send_access(cbam_pkg::CMD_CPU_READ,  16'hBFFF, 8'h00);
        send_access(cbam_pkg::CMD_PPU_READ,  16'h0000, 8'h00);
        send_access(cbam_pkg::CMD_PPU_READ,  16'hDFFF, 8'h00);
        send_access(cbam_pkg::CMD_PPU_WRITE, 16'h1FFF, 8'h5A);
        // nametable rom, horizontal
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'hE000, 8'h11);
        send_access(cbam_pkg::CMD_PPU_READ,  16'h2C00, 8'h00);
        send_access(cbam_pkg::CMD_PPU_WRITE, 16'h3FFF, 8'hC3);
        // nametable ram, horizontal then vertical
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'hEFFF, 8'h01);
        send_access(cbam_pkg::CMD_PPU_READ,  16'h2800, 8'h00);
        send_access(cbam_pkg::CMD_CPU_WRITE, 16'hE000, 8'hEE);
        send_access(cbam_pkg::CMD_PPU_WRITE, 16'h2FFF, 8'h00);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                wait_until_idle();
                configure(phase);
            end
            idling_on = (phase != PHASES - 1);
            if (phase == 0)
                run_directed();
            repeat (ITEMS_PER_PHASE) send_random_access();
        end
        wait_until_idle();
        sb.check_drained();
        $display("%0d accesses under %0d register settings, %0d bank writes, %0d matched",
                 sb.accesses_noted, settings_used, sb.bank_writes, sb.matched_count);
        $display("targets: sysram %0d ppu %0d apu %0d backup %0d prg %0d",
                 sb.target_hits[cbam_pkg::TGT_SYSRAM], sb.target_hits[cbam_pkg::TGT_PPUREG],
                 sb.target_hits[cbam_pkg::TGT_APUREG], sb.target_hits[cbam_pkg::TGT_BACKUP],
                 sb.target_hits[cbam_pkg::TGT_PRG]);
        $display("targets: chr rom %0d nt %0d none %0d chr ram %0d",
                 sb.target_hits[cbam_pkg::TGT_CHRROM], sb.target_hits[cbam_pkg::TGT_NTRAM],
                 sb.target_hits[cbam_pkg::TGT_NONE], sb.target_hits[cbam_pkg::TGT_CHRRAM]);
        if (sb.error_count == 0)
            $display("cartridge_bank_address_mapper test passed");
        else
            $display("cartridge_bank_address_mapper test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/cbam_pkg.sv
hdl/cbam_regs.sv
hdl/cbam_decode.sv
hdl/cartridge_bank_address_mapper.sv
hdl/cbam_checker.sv
bench/cbam_scoreboard_pkg.sv
bench/cartridge_bank_address_mapper_test.sv
